// ===== src/rpmt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpmt_pkg
// Shared types and constants for the range product tree.
// ----------------------------------------------------------------------------
package rpmt_pkg;

	localparam int unsigned LeafCountDefault = 1024;
	localparam logic [29:0] Modulus = 30'd1000000007;
	localparam logic [29:0] Neutral = 30'd1;
	// Reciprocal of the modulus scaled by 2^60, for the quotient estimate.
	localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / 64'(Modulus));

	// Controller states, one-hot.
	typedef enum logic [11:0] {
		ST_CLEAR   = 12'b000000000001,
		ST_IDLE    = 12'b000000000010,
		ST_UREAD   = 12'b000000000100,
		ST_UWAIT   = 12'b000000001000,
		ST_UMUL    = 12'b000000010000,
		ST_UWRITE  = 12'b000000100000,
		ST_QSTEP   = 12'b000001000000,
		ST_QWAIT   = 12'b000010000000,
		ST_QMUL    = 12'b000100000000,
		ST_RED     = 12'b001000000000,
		ST_DONE    = 12'b010000000000,
		ST_UWAIT2  = 12'b100000000000
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic mul_start;   // start modular multiply of op_a * op_b
		logic acc_load;    // acc <= multiplier result
		logic acc_init;    // acc <= one at the start of a query
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic mul_done;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== src/rpmt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpmt_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module rpmt_ram #(
	parameter int unsigned Width = 30,
	parameter int unsigned Depth = 2048
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(Depth)-1:0] waddr,
	input  wire [Width-1:0]         wdata,
	input  wire [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]        rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/rpmt_modmul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpmt_modmul
// Multi-cycle modular multiplier: a 30x30 product is registered first,
// then reduced by a Barrett quotient estimate and two final subtractions.
// ----------------------------------------------------------------------------
module rpmt_modmul
	import rpmt_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [29:0] op_a,
	input  wire  [29:0] op_b,
	output logic        done,
	output logic [29:0] result
);
	logic [59:0] prod_q;
	logic [30:0] quo_q;
	logic [31:0] rem_q;
	logic [29:0] result_q;
	logic        prod_vld_q, quo_vld_q, rem_vld_q;
	logic [61:0] quo_full;
	logic [31:0] qm_low;
	logic [31:0] r1, r2;

	// The estimated quotient falls short by at most two, so the remainder
	// before correction is below three times the modulus and fits 32 bits.
	always_comb begin
		quo_full = 62'(prod_q[59:29]) * 62'(BarrettMu);
		qm_low   = 32'(quo_q) * 32'(Modulus);
		r1 = (rem_q >= 32'(Modulus)) ? rem_q - 32'(Modulus) : rem_q;
		r2 = (r1 >= 32'(Modulus)) ? r1 - 32'(Modulus) : r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_q <= 1'b0;
			quo_vld_q  <= 1'b0;
			rem_vld_q  <= 1'b0;
			done       <= 1'b0;
		end else begin
			prod_vld_q <= start;
			quo_vld_q  <= prod_vld_q;
			rem_vld_q  <= quo_vld_q;
			done       <= rem_vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= 60'(op_a) * 60'(op_b);
		end
		if (prod_vld_q) begin
			quo_q <= quo_full[61:31];
		end
		if (quo_vld_q) begin
			rem_q <= prod_q[31:0] - qm_low;
		end
		if (rem_vld_q) begin
			result_q <= r2[29:0];
		end
	end

	assign result = result_q;
endmodule
`default_nettype wire

// ===== src/rpmt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpmt_datapath
// Accumulator and operand selection around the modular multiplier.
// ----------------------------------------------------------------------------
module rpmt_datapath
	import rpmt_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  dp_cmd_t     cmd,
	input  wire         use_acc,
	input  wire  [29:0] op_a,
	input  wire  [29:0] op_b,
	output dp_sts_t     sts,
	output logic [29:0] mul_result,
	output logic [29:0] acc
);
	logic [29:0] acc_q;
	logic        done;

	rpmt_modmul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.op_a  (use_acc ? acc_q : op_a),
		.op_b  (op_b),
		.done  (done),
		.result(mul_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= Neutral;
		end else if (cmd.acc_load) begin
			acc_q <= mul_result;
		end else if (cmd.acc_init) begin
			acc_q <= Neutral;
		end
	end

	assign sts.mul_done = done;
	assign acc = acc_q;
endmodule
`default_nettype wire

// ===== src/rpmt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpmt_ctrl
// Sequencer: clearing pass, leaf update walk and range query walk.
// ----------------------------------------------------------------------------
module rpmt_ctrl
	import rpmt_pkg::*;
#(
	parameter int unsigned LeafCount = LeafCountDefault
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire                     mode,
	input  wire  [9:0]              position,
	input  wire  [10:0]             range_end,
	output logic                    busy,
	output logic                    valid,
	output logic [29:0]             product,
	// memory
	output logic                    we,
	output logic [$clog2(2*LeafCount)-1:0] waddr,
	output logic [29:0]             wdata,
	output logic [$clog2(2*LeafCount)-1:0] raddr,
	input  wire  [29:0]             rdata,
	// datapath
	output dp_cmd_t                 cmd,
	output logic                    use_acc,
	output logic [29:0]             op_a,
	output logic [29:0]             op_b,
	input  dp_sts_t                 sts,
	input  wire  [29:0]             mul_result,
	input  wire  [29:0]             acc
);
	localparam int unsigned AW = $clog2(2*LeafCount);
	localparam logic [AW:0] LeafC = (AW+1)'(LeafCount);

	state_t      state_q;
	logic [AW:0] node_q, lo_q, hi_q;
	logic [29:0] left_q;
	logic        hi_side_q;  // the hi-side node is in flight
	logic [31:0] ext_pos, ext_end;

	assign ext_pos = 32'(position);
	assign ext_end = (32'(range_end) > 32'(LeafCount)) ? 32'(LeafCount) : 32'(range_end);

	assign busy = (state_q != ST_IDLE);
	assign op_a = left_q;
	assign op_b = rdata;

	always_comb begin
		we      = 1'b0;
		waddr   = node_q[AW-1:0];
		wdata   = mul_result;
		raddr   = node_q[AW-1:0];
		cmd     = '0;
		use_acc = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				wdata = Neutral;
			end
			ST_UREAD: raddr = {node_q[AW-2:0], 1'b0};
			ST_UWAIT: raddr = {node_q[AW-2:0], 1'b1};
			ST_UWAIT2: raddr = {node_q[AW-2:0], 1'b1};
			ST_UMUL: begin
				raddr = {node_q[AW-2:0], 1'b1};
				cmd.mul_start = 1'b1;
			end
			ST_UWRITE: begin
				we = sts.mul_done;
			end
			ST_QSTEP: raddr = hi_side_q ? AW'(hi_q - 1'b1) : lo_q[AW-1:0];
			ST_QWAIT: raddr = hi_side_q ? AW'(hi_q - 1'b1) : lo_q[AW-1:0];
			ST_QMUL: begin
				raddr = hi_side_q ? AW'(hi_q - 1'b1) : lo_q[AW-1:0];
				cmd.mul_start = 1'b1;
				use_acc = 1'b1;
			end
			ST_RED: cmd.acc_load = sts.mul_done;
			ST_IDLE: cmd.acc_init = start && mode;
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			node_q    <= '0;
			valid     <= 1'b0;
			hi_side_q <= 1'b0;
		end else begin
			valid <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					node_q <= node_q + 1'b1;
					if (node_q == (2*LeafC - 1'b1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: if (start) begin
					if (!mode) begin
						// The leaf itself is written on the accepting edge by the top level,
						// so the walk starts at its parent.
						if (ext_pos < 32'(LeafCount)) begin
							node_q  <= (LeafC + (AW+1)'(position)) >> 1;
							state_q <= ST_UREAD;
						end
					end else if (ext_pos >= ext_end) begin
						product <= Neutral;
						valid   <= 1'b1;
					end else begin
						lo_q <= LeafC + (AW+1)'(position);
						hi_q <= LeafC + (AW+1)'(ext_end);
						hi_side_q <= 1'b0;
						state_q <= ST_QSTEP;
					end
				end
				ST_UREAD: state_q <= ST_UWAIT;
				ST_UWAIT: begin
					left_q  <= rdata;
					state_q <= ST_UWAIT2;
				end
				ST_UWAIT2: state_q <= ST_UMUL;
				ST_UMUL: state_q <= ST_UWRITE;
				ST_UWRITE: if (sts.mul_done) begin
					if (node_q == 1) begin
						state_q <= ST_IDLE;
					end else begin
						node_q  <= node_q >> 1;
						state_q <= ST_UREAD;
					end
				end
				ST_QSTEP: begin
					if (lo_q >= hi_q) begin
						state_q <= ST_DONE;
					end else if (!hi_side_q && lo_q[0]) begin
						state_q <= ST_QWAIT;
					end else if (hi_q[0] && (!hi_side_q || lo_q < hi_q)) begin
						hi_side_q <= 1'b1;
						if (!hi_side_q) state_q <= ST_QSTEP;
						else state_q <= ST_QWAIT;
					end else begin
						lo_q <= lo_q >> 1;
						hi_q <= hi_q >> 1;
						hi_side_q <= 1'b0;
					end
				end
				ST_QWAIT: state_q <= ST_QMUL;
				ST_QMUL: state_q <= ST_RED;
				ST_RED: if (sts.mul_done) begin
					if (hi_side_q) begin
						lo_q <= lo_q >> 1;
						hi_q <= (hi_q - 1'b1) >> 1;
						hi_side_q <= 1'b0;
					end else begin
						lo_q <= lo_q + 1'b1;
						hi_side_q <= 1'b1;
					end
					state_q <= ST_QSTEP;
				end
				ST_DONE: begin
					product <= acc;
					valid   <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> state_q == ST_IDLE) else $error("result while busy");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !we) else $error("write while idle");
`endif
endmodule
`default_nettype wire

// ===== src/range_product_mod_tree.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// range_product_mod_tree
// Product tree modulo 1000000007 with leaf update and range query.
//
//  channel  | handshake       | words
//  command  | start / busy    | mode, position, leaf_value, range_end
//  result   | valid strobe    | product
//
// An update keeps busy high while it walks from the leaf's parent to the root:
// each level reads both children, starts one multiply and waits for reduction.
// A query multiplies boundary nodes into the accumulator, shifts up a level
// and delivers; an empty range answers in the cycle after acceptance.
// After reset a clearing pass sets all 2*LEAF_COUNT nodes to one; busy is high.
// Results cannot be stalled; valid is high for one cycle.
// ----------------------------------------------------------------------------
module range_product_mod_tree
	import rpmt_pkg::*;
#(
	parameter int unsigned LEAF_COUNT = LeafCountDefault
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         mode,
	input  wire  [9:0]  position,
	input  wire  [29:0] leaf_value,
	input  wire  [10:0] range_end,
	output logic        valid,
	output logic [29:0] product
);
	localparam int unsigned AW = $clog2(2*LEAF_COUNT);

	logic          we_c, we;
	logic [AW-1:0] waddr_c, waddr, raddr;
	logic [29:0]   wdata_c, wdata, rdata, op_a, op_b, mul_result, acc;
	dp_cmd_t       cmd;
	dp_sts_t       sts;
	logic          use_acc, leaf_wr;
	logic [29:0]   red_val;

	assign leaf_wr = start && !busy && !mode && (32'(position) < 32'(LEAF_COUNT));
	assign red_val = (leaf_value >= Modulus) ? 30'(leaf_value - Modulus) : leaf_value;
	assign we    = we_c | leaf_wr;
	assign waddr = leaf_wr ? AW'(LEAF_COUNT + 32'(position)) : waddr_c;
	assign wdata = leaf_wr ? red_val : wdata_c;

	rpmt_ctrl #(.LeafCount(LEAF_COUNT)) u_ctrl (
		.clk, .arst_n, .start, .mode, .position, .range_end,
		.busy, .valid, .product,
		.we(we_c), .waddr(waddr_c), .wdata(wdata_c), .raddr, .rdata,
		.cmd, .use_acc, .op_a, .op_b, .sts, .mul_result, .acc
	);

	rpmt_datapath u_dp (
		.clk, .arst_n, .cmd, .use_acc, .op_a, .op_b, .sts, .mul_result, .acc
	);

	rpmt_ram #(.Width(30), .Depth(2*LEAF_COUNT)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);
endmodule
`default_nettype wire
